/* hw/rtl/rtch_pkg.sv */
// Package for the ray/triangle closest-hit block: payload structs, register indexes,
// constants and the Q16.16 helper functions. No dependencies.
package rtch_pkg;

	localparam int unsigned MaxTrianglesDefault = 65536;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;
	localparam logic signed [64:0] NearZeroDenom = 65'sd7;
	localparam logic signed [64:0] OneQ = 65'sd65536;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_MAX_DIST = 3'd6,
		REG_MIN_DIST = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]         axis;
		logic signed [31:0] slope_u;
		logic signed [31:0] slope_v;
		logic signed [31:0] plane_offset;
		logic signed [31:0] beta_u;
		logic signed [31:0] beta_v;
		logic signed [31:0] beta_const;
		logic signed [31:0] gamma_u;
		logic signed [31:0] gamma_v;
		logic signed [31:0] gamma_const;
		logic               last_triangle;
	} tri_in_t;

	typedef struct packed {
		logic        hit;
		logic [30:0] hit_distance;
		logic [15:0] hit_index;
		logic        done_res;
	} hit_out_t;

	// Ray state in the u, v, k axis order, used by the back part.
	typedef struct packed {
		logic signed [31:0] ou;
		logic signed [31:0] ov;
		logic signed [31:0] ok;
		logic signed [31:0] du;
		logic signed [31:0] dv;
		logic signed [31:0] dk;
	} ray_uvk_t;

	// Queue entry: a classified triangle.
	typedef struct packed {
		tri_in_t     item;
		logic        test;
		logic [15:0] index;
		logic        first;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLANE,
		ST_CHECK,
		ST_DIV,
		ST_HIT,
		ST_BARY,
		ST_ACC,
		ST_DONE
	} bk_state_t;

	// Q16.16 product, floor of the exact product over 65536.
	function automatic logic signed [64:0] qmul(input logic signed [32:0] a,
		input logic signed [32:0] b);
		logic signed [65:0] p;
		begin
			p = a * b;
			qmul = 65'(p >>> 16);
		end
	endfunction

	function automatic logic signed [32:0] sat32(input logic signed [65:0] x);
		begin
			if (x > 66'sd2147483647) sat32 = 33'sd2147483647;
			else if (x < -66'sd2147483648) sat32 = -33'sd2147483648;
			else sat32 = x[32:0];
		end
	endfunction

endpackage

/* hw/rtl/ray_triangle_closest_hit_top.sv */
// Ray/triangle closest-hit block: top level with configuration registers.
// Depends on rtch_pkg, rtch_front and rtch_back.
// One triangle is tested at a time. In the back part a triangle goes through the plane
// step, the check, the one-bit-per-cycle distance divide and then, if it passes the
// distance check, the hit, barycentric and accumulate steps; one rejected before the divide
// (near-parallel plane, axis 3 or past the triangle limit) skips it. A two-entry queue in
// front lets the next triangles be accepted while one is tested, and the last triangle of
// a ray holds the back part until the output register is free.
module ray_triangle_closest_hit_top import rtch_pkg::*; #(
	parameter int unsigned MaxTriangles = MaxTrianglesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  tri_in_t             tri_in,
	input  logic                in_valid,
	output logic                in_ready,
	output hit_out_t            result,
	output logic                out_valid,
	input  logic                out_ready
);
	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];
	logic [30:0] max_q;
	logic [16:0] min_q;
	job_t job;
	logic job_valid, job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0; org_q[1] <= '0; org_q[2] <= '0;
			dir_q[0] <= 32'sd65536; dir_q[1] <= '0; dir_q[2] <= '0;
			max_q <= 31'h7FFFFFFF;
			min_q <= 17'd66;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X: org_q[0] <= cfg_data;
				REG_ORIGIN_Y: org_q[1] <= cfg_data;
				REG_ORIGIN_Z: org_q[2] <= cfg_data;
				REG_DIR_X:    dir_q[0] <= cfg_data;
				REG_DIR_Y:    dir_q[1] <= cfg_data;
				REG_DIR_Z:    dir_q[2] <= cfg_data;
				REG_MAX_DIST: max_q <= cfg_data[30:0];
				REG_MIN_DIST: min_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	rtch_front #(.MaxTriangles(MaxTriangles)) u_front (
		.clk(clk), .arst_n(arst_n), .tri_in(tri_in), .tri_valid(in_valid),
		.tri_ready(in_ready), .job(job), .job_valid(job_valid), .job_ready(job_ready)
	);

	rtch_back u_back (
		.clk(clk), .arst_n(arst_n), .job(job), .job_valid(job_valid),
		.job_ready(job_ready), .org(org_q), .dir(dir_q), .max_dist(max_q),
		.min_dist(min_q), .res(result), .res_valid(out_valid), .res_ready(out_ready)
	);
endmodule

/* hw/rtl/rtch_divider.sv */
// Restoring divider for the hit distance: (|num| << 16) / |denom|, one bit per cycle.
// Depends on rtch_pkg.
module rtch_divider import rtch_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [80:0]  dividend,
	input  logic [63:0]  divisor,
	output logic         busy,
	output logic         done,
	output logic [80:0]  quotient
);
	logic [80:0] quo_q;
	logic [64:0] rem_q;
	logic [63:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] shifted;
	logic [65:0] diff;

	assign shifted = {rem_q[63:0], quo_q[80]};
	assign diff = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd80) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[65]) begin
				rem_q <= diff[64:0];
				quo_q <= {quo_q[79:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[79:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider busy at done");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider started while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= 7'd80) else $error("divider count out of range");
endmodule

/* hw/rtl/rtch_front.sv */
// Front part: accepts triangle transactions, counts stream positions and
// classifies each triangle before it enters the job queue. Depends on rtch_pkg.
module rtch_front import rtch_pkg::*; #(
	parameter int unsigned MaxTriangles = MaxTrianglesDefault,
	parameter int unsigned CntW = $clog2(MaxTriangles + 1)
) (
	input  logic    clk,
	input  logic    arst_n,
	input  tri_in_t tri_in,
	input  logic    tri_valid,
	output logic    tri_ready,
	output job_t    job,
	output logic    job_valid,
	input  logic    job_ready
);
	logic [CntW-1:0] count_q;
	logic [1:0]      fill_q;
	job_t            slot_q [2];
	logic            rd_q;
	logic            wr_q;
	logic            push;
	logic            pop;
	job_t            new_job;

	assign tri_ready = (fill_q != 2'd2);
	assign push = tri_valid && tri_ready;
	assign job_valid = (fill_q != 2'd0);
	assign pop = job_valid && job_ready;
	assign job = slot_q[rd_q];

	always_comb begin
		new_job.item  = tri_in;
		new_job.test  = (count_q < CntW'(MaxTriangles)) && (tri_in.axis != 2'd3);
		new_job.index = 16'(count_q);
		new_job.first = (count_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fill_q  <= '0;
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
				if (tri_in.last_triangle) count_q <= '0;
				else if (count_q < CntW'(MaxTriangles)) count_q <= count_q + 1'b1;
			end
			if (pop) rd_q <= ~rd_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= new_job;
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= 2'd2)
		else $error("queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> fill_q != 2'd2) else $error("push into full queue");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> fill_q != 2'd0) else $error("pop from empty queue");
	a_job_hold: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job_ready |=> job_valid && $stable(job))
		else $error("queue head changed while waiting");
endmodule

/* hw/rtl/rtch_back.sv */
// Back part: runs the plane, distance and barycentric tests on one job at a time
// and keeps the nearest hit. Depends on rtch_pkg and rtch_divider.
module rtch_back import rtch_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  job_t            job,
	input  logic            job_valid,
	output logic            job_ready,
	input  logic signed [31:0] org [3],
	input  logic signed [31:0] dir [3],
	input  logic [30:0]     max_dist,
	input  logic [16:0]     min_dist,
	output hit_out_t        res,
	output logic            res_valid,
	input  logic            res_ready
);
	bk_state_t state_q, state_d;
	job_t      job_q;
	ray_uvk_t  r;
	logic signed [64:0] denom_q, num_q;
	logic signed [32:0] t_q, hu_q, hv_q;
	logic signed [64:0] beta_q, gamma_q;
	logic signed [32:0] best_q;
	logic [15:0] bidx_q;
	logic        found_q;
	hit_out_t    res_q;
	logic        res_valid_q;
	logic        div_start, div_busy, div_done;
	logic [80:0] quo;
	logic [63:0] an, ad;
	logic        neg;
	logic signed [32:0] t_c;
	logic signed [64:0] alpha;
	logic        accept;
	logic        emit;
	logic [1:0]  ku, kv, kk;
	logic signed [64:0] denom_c, num_c, beta_c, gamma_c;

	always_comb begin
		kk = job_q.item.axis;
		ku = (kk == 2'd0) ? 2'd1 : (kk == 2'd1) ? 2'd2 : 2'd0;
		kv = (kk == 2'd0) ? 2'd2 : (kk == 2'd1) ? 2'd0 : 2'd1;
		if (kk == 2'd3) begin
			ku = 2'd0;
			kv = 2'd0;
			kk = 2'd0;
		end
		r.ou = org[ku];
		r.ov = org[kv];
		r.ok = org[kk];
		r.du = dir[ku];
		r.dv = dir[kv];
		r.dk = dir[kk];
	end

	always_comb begin
		denom_c = qmul(r.du, job_q.item.slope_u) + qmul(r.dv, job_q.item.slope_v) +
			65'(r.dk);
		num_c = 65'(job_q.item.plane_offset) - qmul(r.ou, job_q.item.slope_u) -
			qmul(r.ov, job_q.item.slope_v) - 65'(r.ok);
		beta_c = qmul(hu_q, job_q.item.beta_u) + qmul(hv_q, job_q.item.beta_v) +
			65'(job_q.item.beta_const);
		gamma_c = qmul(hu_q, job_q.item.gamma_u) + qmul(hv_q, job_q.item.gamma_v) +
			65'(job_q.item.gamma_const);
	end

	assign an = num_q[64] ? 64'(-num_q) : 64'(num_q);
	assign ad = denom_q[64] ? 64'(-denom_q) : 64'(denom_q);
	assign neg = (num_q[64] != denom_q[64]) && (quo != '0);

	always_comb begin
		if (neg) t_c = (quo > 81'd2147483648) ? -33'sd2147483648 : -$signed({1'b0, quo[31:0]});
		else t_c = (quo > 81'd2147483647) ? 33'sd2147483647 : $signed({1'b0, quo[31:0]});
	end

	assign alpha = OneQ - beta_q - gamma_q;
	assign accept = !beta_q[64] && !gamma_q[64] && !alpha[64] && (alpha <= OneQ) &&
		(t_q < best_q);

	rtch_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({1'b0, an, 16'd0}), .divisor(ad),
		.busy(div_busy), .done(div_done), .quotient(quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (job_valid) state_d = ST_PLANE;
			ST_PLANE: state_d = ST_CHECK;
			ST_CHECK: state_d = div_start ? ST_DIV : ST_DONE;
			ST_DIV:   if (div_done) state_d = ((t_c < $signed({16'd0, min_dist})) ||
				(t_c > best_q)) ? ST_DONE : ST_HIT;
			ST_HIT:   state_d = ST_BARY;
			ST_BARY:  state_d = ST_ACC;
			ST_ACC:   state_d = ST_DONE;
			ST_DONE:  if (!job_q.item.last_triangle || emit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == ST_IDLE);
		div_start = (state_q == ST_CHECK) && job_q.test && (ad >= 64'(NearZeroDenom));
		emit = (state_q == ST_DONE) && job_q.item.last_triangle &&
			(!res_valid_q || res_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			best_q      <= 33'sd2147483647;
			bidx_q      <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PLANE && job_q.first) begin
				best_q  <= {2'b00, max_dist};
				bidx_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_ACC && accept) begin
				best_q  <= t_q;
				bidx_q  <= job_q.index;
				found_q <= 1'b1;
			end
			if (emit) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) job_q <= job;
		if (state_q == ST_PLANE) begin
			denom_q <= denom_c;
			num_q   <= num_c;
		end
		if (state_q == ST_DIV && div_done) t_q <= t_c;
		if (state_q == ST_HIT) begin
			hu_q <= sat32(66'(r.ou) + 66'(qmul(r.du, t_q)));
			hv_q <= sat32(66'(r.ov) + 66'(qmul(r.dv, t_q)));
		end
		if (state_q == ST_BARY) begin
			beta_q  <= beta_c;
			gamma_q <= gamma_c;
		end
		if (emit) begin
			res_q.hit          <= found_q;
			res_q.hit_distance <= best_q[30:0];
			res_q.hit_index    <= bidx_q;
			res_q.done_res     <= 1'b1;
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |=> res_valid_q && $stable(res_q))
		else $error("result changed while waiting");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("divide finished outside its state");
	a_div_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_busy || div_done) else $error("divide state with idle divider");
	a_take_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> state_q == ST_PLANE) else $error("job not taken");
endmodule

/* tb/tb_ray_triangle_closest_hit_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ray_triangle_closest_hit_top: it streams triangles under
// random handshake pressure and checks each closest-hit transaction against a predictor.
// Depends on rtch_pkg and the block's RTL.
module tb_ray_triangle_closest_hit_top;
	import rtch_pkg::*;

	localparam longint LimitCycles = 3000000;
	localparam logic signed [63:0] MaxQ = 64'sd2147483647;
	localparam logic signed [63:0] MinQ = -64'sd2147483648;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	tri_in_t tri_in;
	logic in_valid;
	logic in_ready;
	hit_out_t result;
	logic out_valid;
	logic out_ready;

	ray_triangle_closest_hit_top u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .tri_in(tri_in), .in_valid(in_valid), .in_ready(in_ready),
		.result(result), .out_valid(out_valid), .out_ready(out_ready)
	);

	logic signed [63:0] ray_org [3];
	logic signed [63:0] ray_dir [3];
	logic [30:0] far_limit;
	logic [16:0] near_limit;
	logic signed [63:0] nearest_t;
	logic [15:0] nearest_idx;
	logic any_hit;
	int unsigned tri_pos;

	hit_out_t hits_due[$];
	int errors;
	longint cycles;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LimitCycles) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [127:0] p;
		begin
			p = a * b;
			fx_mul = 64'(p >>> 16);
		end
	endfunction

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
		begin
			clamp32 = (x > MaxQ) ? MaxQ : (x < MinQ) ? MinQ : x;
		end
	endfunction

	function automatic logic hit_distance_of(input tri_in_t tr, output logic signed [63:0] t);
		int k, u, v;
		logic signed [63:0] den, num, hu, hv, bw, gw, aw;
		logic [63:0] an, ad, q;
		begin
			hit_distance_of = 1'b0;
			t = 0;
			k = tr.axis;
			if (k <= 2) begin
				u = (k + 1) % 3;
				v = (k + 2) % 3;
				den = fx_mul(ray_dir[u], 64'(tr.slope_u)) + fx_mul(ray_dir[v], 64'(tr.slope_v))
					+ ray_dir[k];
				if (den >= 7 || den <= -7) begin
					num = 64'(tr.plane_offset) - fx_mul(ray_org[u], 64'(tr.slope_u))
						- fx_mul(ray_org[v], 64'(tr.slope_v)) - ray_org[k];
					an = num < 0 ? -num : num;
					ad = den < 0 ? -den : den;
					q = (an << 16) / ad;
					if (((num < 0) != (den < 0)) && q != 0) t = (q > -MinQ) ? MinQ : -q;
					else t = (q > MaxQ) ? MaxQ : q;
					if (t >= $signed(64'(near_limit)) && t <= nearest_t) begin
						hu = clamp32(ray_org[u] + fx_mul(ray_dir[u], t));
						hv = clamp32(ray_org[v] + fx_mul(ray_dir[v], t));
						bw = fx_mul(hu, 64'(tr.beta_u)) + fx_mul(hv, 64'(tr.beta_v))
							+ 64'(tr.beta_const);
						gw = fx_mul(hu, 64'(tr.gamma_u)) + fx_mul(hv, 64'(tr.gamma_v))
							+ 64'(tr.gamma_const);
						aw = 64'sd65536 - bw - gw;
						hit_distance_of = bw >= 0 && gw >= 0 && aw >= 0 && aw <= 64'sd65536;
					end
				end
			end
		end
	endfunction

	function automatic void predict_hit(input tri_in_t tr);
		logic signed [63:0] t;
		hit_out_t h;
		begin
			if (tri_pos == 0) begin
				nearest_t = 64'(far_limit);
				nearest_idx = '0;
				any_hit = 1'b0;
			end
			if (tri_pos < MaxTrianglesDefault) begin
				if (hit_distance_of(tr, t) && t < nearest_t) begin
					nearest_t = t;
					nearest_idx = tri_pos[15:0];
					any_hit = 1'b1;
				end
				tri_pos++;
			end
			if (tr.last_triangle) begin
				h.hit = any_hit;
				h.hit_distance = nearest_t[30:0];
				h.hit_index = nearest_idx;
				h.done_res = 1'b1;
				hits_due.push_back(h);
				tri_pos = 0;
			end
		end
	endfunction

	always @(posedge clk) begin
		hit_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (hits_due.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				errors++;
			end else begin
				want = hits_due.pop_front();
				if (result.hit !== want.hit || result.hit_distance !== want.hit_distance
					|| result.hit_index !== want.hit_index
					|| result.done_res !== want.done_res) begin
					$display("%0t: expected %p actual %p", $time, want, result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 15);
		if (cycles % 2000 < 700) out_ready <= 1'b1;
		else out_ready <= r > 5;
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			cfg_we <= 1'b0;
			case (idx)
				REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: ray_org[idx] = 64'(signed'(val));
				REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[idx - 3] = 64'(signed'(val));
				REG_MAX_DIST: far_limit = val[30:0];
				REG_MIN_DIST: near_limit = val[16:0];
				default: ;
			endcase
		end
	endtask

	task automatic send_triangle(input tri_in_t tr);
		int gap;
		begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			tri_in <= tr;
			in_valid <= 1'b1;
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			predict_hit(tr);
		end
	endtask

	task automatic drain();
		begin
			in_valid <= 1'b0;
			while (hits_due.size() != 0) @(posedge clk);
			repeat (300) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: rand_word = 32'h8000_0000;
			1: rand_word = 32'h7fff_ffff;
			2: rand_word = '0;
			3: rand_word = 32'(signed'($urandom_range(0, 8 * 65536)) - 4 * 65536);
			default: rand_word = $urandom();
		endcase
	endfunction

	// A triangle around the ray at a chosen distance, with projections laid out so that
	// the ray usually lands inside or near the edges.
	function automatic tri_in_t aimed_triangle(input logic last);
		tri_in_t tr;
		begin
			tr.axis = 2'($urandom_range(0, 2));
			tr.slope_u = 32'(signed'($urandom_range(0, 65536)) - 32768);
			tr.slope_v = 32'(signed'($urandom_range(0, 65536)) - 32768);
			tr.plane_offset = 32'(signed'($urandom_range(0, 40 * 65536)) - 5 * 65536);
			tr.beta_u = 32'(signed'($urandom_range(0, 16384)) - 8192);
			tr.beta_v = 32'(signed'($urandom_range(0, 16384)) - 8192);
			tr.beta_const = $urandom_range(0, 40000);
			tr.gamma_u = 32'(signed'($urandom_range(0, 16384)) - 8192);
			tr.gamma_v = 32'(signed'($urandom_range(0, 16384)) - 8192);
			tr.gamma_const = $urandom_range(0, 40000);
			tr.last_triangle = last;
			aimed_triangle = tr;
		end
	endfunction

	function automatic tri_in_t noise_triangle(input logic last);
		tri_in_t tr;
		begin
			tr.axis = 2'($urandom_range(0, 3));
			tr.slope_u = rand_word();
			tr.slope_v = rand_word();
			tr.plane_offset = rand_word();
			tr.beta_u = rand_word();
			tr.beta_v = rand_word();
			tr.beta_const = rand_word();
			tr.gamma_u = rand_word();
			tr.gamma_v = rand_word();
			tr.gamma_const = rand_word();
			tr.last_triangle = last;
			noise_triangle = tr;
		end
	endfunction

	task automatic test_directed();
		tri_in_t tr;
		begin
			// Plane x = 5 hit inside, then a nearer tie pair, a miss and an axis-3 last triangle.
			tr = '0;
			tr.plane_offset = 5 * 65536;
			tr.beta_const = 16384;
			tr.gamma_const = 16384;
			send_triangle(tr);
			tr.plane_offset = 3 * 65536;
			send_triangle(tr);
			send_triangle(tr);
			tr.beta_const = -1;
			tr.plane_offset = 65536;
			send_triangle(tr);
			tr.axis = 2'd3;
			tr.last_triangle = 1'b1;
			send_triangle(tr);
			// Near-zero denominator, distance below minimum, alpha above one, negative distance, edge hit.
			tr = '0;
			tr.axis = 2'd1;
			tr.plane_offset = 65536;
			send_triangle(tr);
			tr.axis = 2'd0;
			tr.plane_offset = 32;
			send_triangle(tr);
			tr.plane_offset = 65536;
			tr.beta_const = -100;
			tr.gamma_const = 50;
			send_triangle(tr);
			tr.beta_const = 0;
			tr.gamma_const = 65536;
			tr.plane_offset = -65536;
			send_triangle(tr);
			tr.plane_offset = 2 * 65536;
			tr.gamma_const = 65536;
			tr.last_triangle = 1'b1;
			send_triangle(tr);
			// Field extremes.
			tr = '1;
			tr.axis = 2'd2;
			send_triangle(tr);
			tr = '0;
			tr.slope_u = 32'h8000_0000;
			tr.slope_v = 32'h7fff_ffff;
			tr.plane_offset = 32'h7fff_ffff;
			tr.beta_u = 32'h8000_0000;
			tr.gamma_v = 32'h7fff_ffff;
			tr.beta_const = 32'h7fff_ffff;
			tr.last_triangle = 1'b1;
			send_triangle(tr);
			tr = '1;
			send_triangle(tr);
			drain();
		end
	endtask

	task automatic load_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, dmax, dmin);
		begin
			write_reg(REG_ORIGIN_X, ox);
			write_reg(REG_ORIGIN_Y, oy);
			write_reg(REG_ORIGIN_Z, oz);
			write_reg(REG_DIR_X, dx);
			write_reg(REG_DIR_Y, dy);
			write_reg(REG_DIR_Z, dz);
			write_reg(REG_MAX_DIST, dmax);
			write_reg(REG_MIN_DIST, dmin);
		end
	endtask

	task automatic test_random_rays(input int count);
		int n, len;
		begin
			n = 0;
			while (n < count) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 4) == 0) send_triangle(noise_triangle(i == len - 1));
					else send_triangle(aimed_triangle(i == len - 1));
				end
				n += len;
			end
			drain();
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ORIGIN_X;
		cfg_data = '0;
		tri_in = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		ray_org = '{0, 0, 0};
		ray_dir = '{65536, 0, 0};
		far_limit = 31'h7fff_ffff;
		near_limit = 17'd66;
		tri_pos = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_rays(150);
		load_ray(32'h0001_0000, 32'hffff_8000, 32'h0000_4000, 32'h0000_8000,
			32'h0001_0000, 32'hffff_0000, 32'd20 * 65536, 32'd0);
		test_random_rays(150);
		load_ray(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff,
			32'h8000_0000, 32'h1, 32'h7fff_ffff, 32'd65536);
		test_random_rays(100);
		load_ray($urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), 32'd0, 32'd1);
		test_random_rays(60);
		load_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'd8 * 65536, 32'd66);
		test_random_rays(190);

		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
